[src/gtd_pkg.sv]
`default_nettype none

package gtd_pkg;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned CoefW    = 17;
  localparam int unsigned TrigW    = 16;
  localparam int unsigned AccW     = 40;
  localparam int unsigned HalfW    = 20;
  localparam int unsigned MulW     = 32;
  localparam int unsigned ProdW    = 64;
  localparam int unsigned SumW     = 58;
  localparam int unsigned RndW     = 44;
  localparam int unsigned ResW     = 46;
  localparam int unsigned PartW    = 45;
  localparam int unsigned SqW      = 63;
  localparam int unsigned PowerW   = 62;
  localparam int unsigned DataW    = 64;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned RoundBit = 14;

  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};
  localparam logic [PowerW-1:0]      PowerMax = {PowerW{1'b1}};
  localparam logic [SqW-1:0]         SqOverflow = {1'b1, {(SqW-1){1'b0}}};

  localparam logic signed [CoefW-1:0] CoefReset = 17'sd0;
  localparam logic signed [TrigW-1:0] CosReset  = 16'sd16384;
  localparam logic signed [TrigW-1:0] SinReset  = 16'sd0;
  localparam logic [PowerW-1:0]       ThrReset  = 62'd0;

  typedef enum logic [1:0] {
    REG_COEF = 2'd0,
    REG_COS  = 2'd1,
    REG_SIN  = 2'd2,
    REG_THR  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic signed [CoefW-1:0] coef;
    logic signed [TrigW-1:0] cos_term;
    logic signed [TrigW-1:0] sin_term;
    logic [PowerW-1:0]       threshold;
  } cfg_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_MUL_LO,
    DP_MUL_HI,
    DP_RES_UPD,
    DP_RE_UPD,
    DP_IM_UPD,
    DP_SQ_RE,
    DP_SQ_IM,
    DP_POWER
  } dp_op_e;

  typedef enum logic {
    A_PREV,
    A_PREV2
  } a_sel_e;

  typedef enum logic [1:0] {
    B_COEF,
    B_COS,
    B_SIN
  } b_sel_e;

  typedef struct packed {
    dp_op_e op;
    a_sel_e a_sel;
    b_sel_e b_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic out_valid;
  } dp_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RES_LO,
    ST_RES_HI,
    ST_RES_UPD,
    ST_COS_LO,
    ST_COS_HI,
    ST_RE_UPD,
    ST_SIN_LO,
    ST_SIN_HI,
    ST_IM_UPD,
    ST_SQ_RE,
    ST_SQ_IM,
    ST_POWER
  } state_e;

endpackage

`default_nettype wire

[src/gtd_regs.sv]
`default_nettype none

module gtd_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [gtd_pkg::AddrW-1:0]   paddr,
  input  wire logic [gtd_pkg::DataW-1:0]   pwdata,
  output logic      [gtd_pkg::DataW-1:0]   prdata,
  output logic                             pready,
  output gtd_pkg::cfg_t                    cfg_o
);

  gtd_pkg::cfg_t    cfg_q, cfg_d;
  gtd_pkg::reg_idx_e idx;
  logic             wr_en;

  assign idx    = gtd_pkg::reg_idx_e'(paddr[gtd_pkg::AddrW-1:3]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        gtd_pkg::REG_COEF: cfg_d.coef      = pwdata[gtd_pkg::CoefW-1:0];
        gtd_pkg::REG_COS:  cfg_d.cos_term  = pwdata[gtd_pkg::TrigW-1:0];
        gtd_pkg::REG_SIN:  cfg_d.sin_term  = pwdata[gtd_pkg::TrigW-1:0];
        gtd_pkg::REG_THR:  cfg_d.threshold = pwdata[gtd_pkg::PowerW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      gtd_pkg::REG_COEF: prdata = {{(gtd_pkg::DataW-gtd_pkg::CoefW){1'b0}}, cfg_q.coef};
      gtd_pkg::REG_COS:  prdata = {{(gtd_pkg::DataW-gtd_pkg::TrigW){1'b0}}, cfg_q.cos_term};
      gtd_pkg::REG_SIN:  prdata = {{(gtd_pkg::DataW-gtd_pkg::TrigW){1'b0}}, cfg_q.sin_term};
      gtd_pkg::REG_THR:  prdata = {{(gtd_pkg::DataW-gtd_pkg::PowerW){1'b0}}, cfg_q.threshold};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef      <= gtd_pkg::CoefReset;
      cfg_q.cos_term  <= gtd_pkg::CosReset;
      cfg_q.sin_term  <= gtd_pkg::SinReset;
      cfg_q.threshold <= gtd_pkg::ThrReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

[src/gtd_ctrl.sv]
`default_nettype none

module gtd_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          out_stall_i,
  input  gtd_pkg::dp_status_t status_i,
  output gtd_pkg::dp_cmd_t   cmd_o,
  output logic               in_stall_o
);

  gtd_pkg::state_e state_q, state_d;
  logic            out_free;

  assign out_free   = !status_i.out_valid || !out_stall_i;
  assign in_stall_o = (state_q != gtd_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gtd_pkg::ST_IDLE:    if (in_valid_i) begin
        state_d = gtd_pkg::ST_RES_LO;
      end
      gtd_pkg::ST_RES_LO:  state_d = gtd_pkg::ST_RES_HI;
      gtd_pkg::ST_RES_HI:  state_d = gtd_pkg::ST_RES_UPD;
      gtd_pkg::ST_RES_UPD: state_d = status_i.last ? gtd_pkg::ST_COS_LO : gtd_pkg::ST_IDLE;
      gtd_pkg::ST_COS_LO:  state_d = gtd_pkg::ST_COS_HI;
      gtd_pkg::ST_COS_HI:  state_d = gtd_pkg::ST_RE_UPD;
      gtd_pkg::ST_RE_UPD:  state_d = gtd_pkg::ST_SIN_LO;
      gtd_pkg::ST_SIN_LO:  state_d = gtd_pkg::ST_SIN_HI;
      gtd_pkg::ST_SIN_HI:  state_d = gtd_pkg::ST_IM_UPD;
      gtd_pkg::ST_IM_UPD:  state_d = gtd_pkg::ST_SQ_RE;
      gtd_pkg::ST_SQ_RE:   state_d = gtd_pkg::ST_SQ_IM;
      gtd_pkg::ST_SQ_IM:   state_d = gtd_pkg::ST_POWER;
      gtd_pkg::ST_POWER:   if (out_free) begin
        state_d = gtd_pkg::ST_IDLE;
      end
      default: state_d = gtd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op    = gtd_pkg::DP_NOP;
    cmd_o.a_sel = gtd_pkg::A_PREV;
    cmd_o.b_sel = gtd_pkg::B_COEF;
    unique case (state_q)
      gtd_pkg::ST_IDLE:    if (in_valid_i) begin
        cmd_o.op = gtd_pkg::DP_LOAD;
      end
      gtd_pkg::ST_RES_LO:  cmd_o.op = gtd_pkg::DP_MUL_LO;
      gtd_pkg::ST_RES_HI:  cmd_o.op = gtd_pkg::DP_MUL_HI;
      gtd_pkg::ST_RES_UPD: cmd_o.op = gtd_pkg::DP_RES_UPD;
      gtd_pkg::ST_COS_LO: begin
        cmd_o.op    = gtd_pkg::DP_MUL_LO;
        cmd_o.a_sel = gtd_pkg::A_PREV2;
        cmd_o.b_sel = gtd_pkg::B_COS;
      end
      gtd_pkg::ST_COS_HI: begin
        cmd_o.op    = gtd_pkg::DP_MUL_HI;
        cmd_o.a_sel = gtd_pkg::A_PREV2;
        cmd_o.b_sel = gtd_pkg::B_COS;
      end
      gtd_pkg::ST_RE_UPD:  cmd_o.op = gtd_pkg::DP_RE_UPD;
      gtd_pkg::ST_SIN_LO: begin
        cmd_o.op    = gtd_pkg::DP_MUL_LO;
        cmd_o.a_sel = gtd_pkg::A_PREV2;
        cmd_o.b_sel = gtd_pkg::B_SIN;
      end
      gtd_pkg::ST_SIN_HI: begin
        cmd_o.op    = gtd_pkg::DP_MUL_HI;
        cmd_o.a_sel = gtd_pkg::A_PREV2;
        cmd_o.b_sel = gtd_pkg::B_SIN;
      end
      gtd_pkg::ST_IM_UPD:  cmd_o.op = gtd_pkg::DP_IM_UPD;
      gtd_pkg::ST_SQ_RE:   cmd_o.op = gtd_pkg::DP_SQ_RE;
      gtd_pkg::ST_SQ_IM:   cmd_o.op = gtd_pkg::DP_SQ_IM;
      gtd_pkg::ST_POWER:   if (out_free) begin
        cmd_o.op = gtd_pkg::DP_POWER;
      end
      default: cmd_o.op = gtd_pkg::DP_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gtd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[src/gtd_datapath.sv]
`default_nettype none

module gtd_datapath (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  gtd_pkg::dp_cmd_t                        cmd_i,
  input  gtd_pkg::cfg_t                           cfg_i,
  input  wire logic signed [gtd_pkg::SampleW-1:0] sample_i,
  input  wire logic                               last_sample_i,
  input  wire logic                               out_stall_i,
  output gtd_pkg::dp_status_t                     status_o,
  output logic                                    out_valid_o,
  output logic                                    tone_detected_o,
  output logic             [gtd_pkg::PowerW-1:0]  block_power_o
);

  logic signed [gtd_pkg::AccW-1:0]    prev_q, prev_d, prev2_q, prev2_d;
  logic                               last_q, last_d;
  logic                               valid_q, valid_d;
  logic signed [gtd_pkg::SampleW-1:0] x_q, x_d;
  logic signed [gtd_pkg::ProdW-1:0]   prod_q, prod_d;
  logic                               sat_q, sat_d;
  logic signed [gtd_pkg::SumW-1:0]    acc_q, acc_d;
  logic signed [gtd_pkg::PartW-1:0]   re_q, re_d, im_q, im_d;
  logic        [gtd_pkg::SqW-1:0]     sqre_q, sqre_d;
  logic        [gtd_pkg::PowerW-1:0]  power_q, power_d;
  logic                               det_q, det_d;

  logic signed [gtd_pkg::AccW-1:0]    a_val;
  logic signed [gtd_pkg::MulW-1:0]    b_val, mul_a, mul_b;
  logic signed [gtd_pkg::ProdW-1:0]   mul_p;
  logic        [gtd_pkg::PartW-1:0]   re_abs, im_abs;
  logic signed [gtd_pkg::SumW-1:0]    full, rnd_full;
  logic signed [gtd_pkg::RndW-1:0]    rnd;
  logic signed [gtd_pkg::ResW-1:0]    s_val;
  logic signed [gtd_pkg::AccW-1:0]    s_sat;
  logic        [gtd_pkg::SqW-1:0]     sq_cur;
  logic        [gtd_pkg::ProdW-1:0]   pw_sum;
  logic        [gtd_pkg::PowerW-1:0]  pw;

  assign a_val = (cmd_i.a_sel == gtd_pkg::A_PREV2) ? prev2_q : prev_q;

  always_comb begin
    unique case (cmd_i.b_sel)
      gtd_pkg::B_COEF: b_val = {{(gtd_pkg::MulW-gtd_pkg::CoefW){cfg_i.coef[gtd_pkg::CoefW-1]}},
                                cfg_i.coef};
      gtd_pkg::B_COS:  b_val = {{(gtd_pkg::MulW-gtd_pkg::TrigW){cfg_i.cos_term[gtd_pkg::TrigW-1]}},
                                cfg_i.cos_term};
      gtd_pkg::B_SIN:  b_val = {{(gtd_pkg::MulW-gtd_pkg::TrigW){cfg_i.sin_term[gtd_pkg::TrigW-1]}},
                                cfg_i.sin_term};
      default: b_val = '0;
    endcase
  end

  assign re_abs = re_q[gtd_pkg::PartW-1] ? (gtd_pkg::PartW'(0) - re_q) : re_q;
  assign im_abs = im_q[gtd_pkg::PartW-1] ? (gtd_pkg::PartW'(0) - im_q) : im_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      gtd_pkg::DP_MUL_LO: begin
        mul_a = {{(gtd_pkg::MulW-gtd_pkg::HalfW){1'b0}}, a_val[gtd_pkg::HalfW-1:0]};
        mul_b = b_val;
      end
      gtd_pkg::DP_MUL_HI: begin
        mul_a = {{(gtd_pkg::MulW-gtd_pkg::HalfW){a_val[gtd_pkg::AccW-1]}},
                 a_val[gtd_pkg::AccW-1:gtd_pkg::HalfW]};
        mul_b = b_val;
      end
      gtd_pkg::DP_SQ_RE: begin
        mul_a = {1'b0, re_abs[gtd_pkg::MulW-2:0]};
        mul_b = {1'b0, re_abs[gtd_pkg::MulW-2:0]};
      end
      gtd_pkg::DP_SQ_IM: begin
        mul_a = {1'b0, im_abs[gtd_pkg::MulW-2:0]};
        mul_b = {1'b0, im_abs[gtd_pkg::MulW-2:0]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // The high partial product is weighted by the lower half width.
  assign full     = $signed({prod_q[gtd_pkg::SumW-gtd_pkg::HalfW-1:0],
                             {gtd_pkg::HalfW{1'b0}}}) + acc_q;
  assign rnd_full = full + gtd_pkg::SumW'(1 << (gtd_pkg::RoundBit - 1));
  assign rnd      = rnd_full[gtd_pkg::SumW-1:gtd_pkg::RoundBit];

  assign s_val = {{(gtd_pkg::ResW-gtd_pkg::SampleW){x_q[gtd_pkg::SampleW-1]}}, x_q}
               + {{(gtd_pkg::ResW-gtd_pkg::RndW){rnd[gtd_pkg::RndW-1]}}, rnd}
               - {{(gtd_pkg::ResW-gtd_pkg::AccW){prev2_q[gtd_pkg::AccW-1]}}, prev2_q};

  always_comb begin
    if ((&s_val[gtd_pkg::ResW-1:gtd_pkg::AccW-1]) ||
        !(|s_val[gtd_pkg::ResW-1:gtd_pkg::AccW-1])) begin
      s_sat = s_val[gtd_pkg::AccW-1:0];
    end else if (s_val[gtd_pkg::ResW-1]) begin
      s_sat = gtd_pkg::AccMin;
    end else begin
      s_sat = gtd_pkg::AccMax;
    end
  end

  assign sq_cur = sat_q ? gtd_pkg::SqOverflow : prod_q[gtd_pkg::SqW-1:0];
  assign pw_sum = {1'b0, sqre_q} + {1'b0, sq_cur};
  assign pw     = (|pw_sum[gtd_pkg::ProdW-1:gtd_pkg::PowerW]) ? gtd_pkg::PowerMax
                                                              : pw_sum[gtd_pkg::PowerW-1:0];

  always_comb begin
    prev_d  = prev_q;
    prev2_d = prev2_q;
    last_d  = last_q;
    x_d     = x_q;
    prod_d  = prod_q;
    sat_d   = sat_q;
    acc_d   = acc_q;
    re_d    = re_q;
    im_d    = im_q;
    sqre_d  = sqre_q;
    power_d = power_q;
    det_d   = det_q;
    valid_d = valid_q & out_stall_i;
    unique case (cmd_i.op)
      gtd_pkg::DP_NOP: ;
      gtd_pkg::DP_LOAD: begin
        x_d    = sample_i;
        last_d = last_sample_i;
      end
      gtd_pkg::DP_MUL_LO: begin
        prod_d = mul_p;
      end
      gtd_pkg::DP_MUL_HI: begin
        prod_d = mul_p;
        acc_d  = prod_q[gtd_pkg::SumW-1:0];
      end
      gtd_pkg::DP_RES_UPD: begin
        prev2_d = prev_q;
        prev_d  = s_sat;
      end
      gtd_pkg::DP_RE_UPD: begin
        re_d = {{(gtd_pkg::PartW-gtd_pkg::AccW){prev_q[gtd_pkg::AccW-1]}}, prev_q}
             - {{(gtd_pkg::PartW-gtd_pkg::RndW){rnd[gtd_pkg::RndW-1]}}, rnd};
      end
      gtd_pkg::DP_IM_UPD: begin
        im_d = {{(gtd_pkg::PartW-gtd_pkg::RndW){rnd[gtd_pkg::RndW-1]}}, rnd};
      end
      gtd_pkg::DP_SQ_RE: begin
        prod_d = mul_p;
        sat_d  = |re_abs[gtd_pkg::PartW-1:gtd_pkg::MulW-1];
      end
      gtd_pkg::DP_SQ_IM: begin
        prod_d = mul_p;
        sat_d  = |im_abs[gtd_pkg::PartW-1:gtd_pkg::MulW-1];
        sqre_d = sq_cur;
      end
      gtd_pkg::DP_POWER: begin
        power_d = pw;
        det_d   = (pw > cfg_i.threshold);
        valid_d = 1'b1;
        prev_d  = '0;
        prev2_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      prev2_q <= '0;
      last_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      prev_q  <= prev_d;
      prev2_q <= prev2_d;
      last_q  <= last_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    prod_q  <= prod_d;
    sat_q   <= sat_d;
    acc_q   <= acc_d;
    re_q    <= re_d;
    im_q    <= im_d;
    sqre_q  <= sqre_d;
    power_q <= power_d;
    det_q   <= det_d;
  end

  assign status_o.last      = last_q;
  assign status_o.out_valid = valid_q;
  assign out_valid_o        = valid_q;
  assign tone_detected_o    = det_q;
  assign block_power_o      = power_q;

endmodule

`default_nettype wire

[src/goertzel_tone_detector_unit.sv]
// Goertzel single-bin tone detector.
// Samples arrive on the input channel (in_valid_i, in_stall_o, sample_i, last_sample_i).
// Each item runs the resonator recurrence on one shared 32x32 multiplier, split into
// low and high halves of the 40-bit accumulator, so the block takes a new item only
// once it is through with the last one; in_stall_o is low only in the idle state.
// An item marked last_sample_i then goes through the final real and imaginary terms
// and the two squares on the same multiplier; its result is loaded into the output
// register in the final power step.
// The result (tone_detected_o, block_power_o) waits under out_valid_o until taken;
// the next item is accepted meanwhile, and a later block's final step waits only if
// the output register is still occupied and out_stall_i is high.
// Configuration uses the APB port at byte addresses 0, 8, 16 and 24 with 64-bit
// data; write it only while the block is idle.
// Reset clears both accumulators and the output valid, and loads the register
// defaults: coefficient 0, cosine 16384, sine 0, threshold 0.
`default_nettype none

module goertzel_tone_detector_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic signed [gtd_pkg::SampleW-1:0] sample_i,
  input  wire logic                               last_sample_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic                                    tone_detected_o,
  output logic             [gtd_pkg::PowerW-1:0]  block_power_o,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic        [gtd_pkg::AddrW-1:0]   paddr,
  input  wire logic        [gtd_pkg::DataW-1:0]   pwdata,
  output logic             [gtd_pkg::DataW-1:0]   prdata,
  output logic                                    pready
);

  gtd_pkg::cfg_t       cfg;
  gtd_pkg::dp_cmd_t    cmd;
  gtd_pkg::dp_status_t status;

  gtd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gtd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o)
  );

  gtd_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_i           (cfg),
    .sample_i        (sample_i),
    .last_sample_i   (last_sample_i),
    .out_stall_i     (out_stall_i),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .tone_detected_o (tone_detected_o),
    .block_power_o   (block_power_o)
  );

endmodule

`default_nettype wire

[src/gtd_checker.sv]
`default_nettype none

module gtd_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_stall_o,
  input wire logic                              last_sample_i,
  input wire logic                              out_valid_o,
  input wire logic                              out_stall_i,
  input wire logic                              tone_detected_o,
  input wire logic [gtd_pkg::PowerW-1:0]        block_power_o
);

  logic in_acc;

  assign in_acc = in_valid_i && !in_stall_o;

  // A result held back by the receiver stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(block_power_o)
      && $stable(tone_detected_o))
    else $error("result changed while stalled");

  // The recurrence keeps the block busy right after an item is taken.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input not stalled after accept");

  // An item that does not close a block frees the input again once its resonator update is done.
  a_plain_item_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !last_sample_i |-> ##4 !in_stall_o)
    else $error("plain item took too long");

  // An item that does not close a block never produces a result.
  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !last_sample_i && !out_valid_o |=> !out_valid_o)
    else $error("result without a last item");

endmodule

bind goertzel_tone_detector_unit gtd_checker u_gtd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .last_sample_i   (last_sample_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .tone_detected_o (tone_detected_o),
  .block_power_o   (block_power_o)
);

`default_nettype wire
